[hdl/nls_pkg.sv]
// Package for the numeric literal scanner: widths, character codes,
// CSR indexes, scanner state encoding and shared structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nls_pkg;

   // Token length counter width and the saturation limit of the length outputs
   localparam int LengthBits = 12;
   localparam int OutBits    = 12;
   localparam int CmpBits    = ((LengthBits > OutBits) ? LengthBits : OutBits) + 1;
   localparam logic [LengthBits-1:0] CountMax = {LengthBits{1'b1}};
   localparam logic [CmpBits-1:0]    OutMax   = CmpBits'((1 << OutBits) - 1);

   // Configuration registers
   localparam int FlagsBits = 5;
   localparam int CapBits   = 12;
   localparam int CsrIdxBits  = 1;
   localparam int CsrDataBits = 12;
   localparam logic [CsrIdxBits-1:0] CsrFormatFlags   = 1'd0;
   localparam logic [CsrIdxBits-1:0] CsrTokenCapacity = 1'd1;
   localparam logic [FlagsBits-1:0]  FlagsReset   = 5'd31;
   localparam logic [CapBits-1:0]    CapacityReset = 12'd64;

   // format_flags bit positions
   localparam int FlagSign  = 0;
   localparam int FlagFloat = 1;
   localparam int Flag0x    = 2;
   localparam int Flag0h    = 3;
   localparam int Flag0b    = 4;

   // Character codes
   localparam logic [7:0] ChNul    = 8'h00;
   localparam logic [7:0] ChPlus   = 8'h2B;
   localparam logic [7:0] ChMinus  = 8'h2D;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChOne    = 8'h31;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChUpperA = 8'h41;
   localparam logic [7:0] ChUpperB = 8'h42;
   localparam logic [7:0] ChUpperE = 8'h45;
   localparam logic [7:0] ChUpperF = 8'h46;
   localparam logic [7:0] ChUpperH = 8'h48;
   localparam logic [7:0] ChUpperX = 8'h58;
   localparam logic [7:0] ChLowerA = 8'h61;
   localparam logic [7:0] ChLowerB = 8'h62;
   localparam logic [7:0] ChLowerE = 8'h65;
   localparam logic [7:0] ChLowerF = 8'h66;
   localparam logic [7:0] ChLowerH = 8'h68;
   localparam logic [7:0] ChLowerX = 8'h78;

   // Token kinds
   localparam logic [2:0] KindInteger  = 3'd0;
   localparam logic [2:0] KindFraction = 3'd1;
   localparam logic [2:0] KindExponent = 3'd2;
   localparam logic [2:0] KindHex      = 3'd3;
   localparam logic [2:0] KindBinary   = 3'd4;

   // Scanner state, one-hot
   typedef enum logic [5:0] {
      ST_INT       = 6'b000001,
      ST_FRAC      = 6'b000010,
      ST_EXP_START = 6'b000100,
      ST_EXP       = 6'b001000,
      ST_HEX       = 6'b010000,
      ST_BIN       = 6'b100000
   } scan_state_type;

   // Everything the scanner carries from one character to the next
   typedef struct packed {
      scan_state_type          state;
      logic [LengthBits-1:0]   count;
      logic                    last_zero;
   } scan_ctx_type;

   // One result beat
   typedef struct packed {
      logic                accepted;
      logic                stored;
      logic [7:0]          char_out;
      logic [OutBits-1:0]  position;
      logic                token_done;
      logic [OutBits-1:0]  token_length;
      logic [2:0]          token_kind;
      logic                truncated;
   } nls_result_type;

   // Saturate the internal count to the output width
   function automatic logic [OutBits-1:0] clip_out(input logic [LengthBits-1:0] count);
      logic [CmpBits-1:0] ext;
      ext = CmpBits'(count);
      if (ext > OutMax) begin
         clip_out = OutBits'(OutMax);
      end else begin
         clip_out = ext[OutBits-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[hdl/nls_channels.sv]
// Valid/ready channel interfaces for the scanner's character input and result output.
// Depends on nls_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface nls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, ch, end_of_input, input ready);
   modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface nls_rsp_if;
   import nls_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic               stored;
   logic [7:0]         char_out;
   logic [OutBits-1:0] position;
   logic               token_done;
   logic [OutBits-1:0] token_length;
   logic [2:0]         token_kind;
   logic               truncated;

   modport source (output valid, accepted, stored, char_out, position, token_done,
                   token_length, token_kind, truncated, input ready);
   modport sink   (input valid, accepted, stored, char_out, position, token_done,
                   token_length, token_kind, truncated, output ready);
endinterface

`default_nettype wire

[hdl/nls_step.sv]
// Per-character scanner decision: classifies the character, picks the next
// scanner context and builds the result beat. Pure logic; depends on nls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nls_step (
   input  wire logic [7:0]                     ch,
   input  wire logic                           end_of_input,
   input  wire logic [nls_pkg::FlagsBits-1:0]  format_flags,
   input  wire logic [nls_pkg::CapBits-1:0]    token_capacity,
   input  wire nls_pkg::scan_ctx_type          ctx,
   output nls_pkg::scan_ctx_type               ctx_next,
   output nls_pkg::nls_result_type             result
);
   import nls_pkg::*;

   logic           live;
   logic           is_digit;
   logic           is_sign;
   logic           is_hex_letter;
   logic           hex_prefix;
   logic           bin_prefix;
   logic           prefix_ok;
   logic           flt;
   logic           take;
   logic           below_cap;
   scan_state_type eff_state;
   scan_state_type next_state;
   logic           next_last_zero;
   logic [2:0]     kind;

   // Character classes
   always_comb begin
      live          = !end_of_input && (ch != ChNul);
      is_digit      = ch inside {[ChZero:ChNine]};
      is_sign       = (ch == ChPlus) || (ch == ChMinus);
      is_hex_letter = ch inside {[ChLowerA:ChLowerF], [ChUpperA:ChUpperF]};
      flt           = format_flags[FlagFloat];
      hex_prefix    = (format_flags[Flag0h] && (ch inside {ChLowerH, ChUpperH})) ||
                      (format_flags[Flag0x] && (ch inside {ChLowerX, ChUpperX}));
      bin_prefix    = format_flags[Flag0b] && (ch inside {ChLowerB, ChUpperB});
      prefix_ok     = (ctx.state == ST_INT) && ctx.last_zero &&
                      (ctx.count == LengthBits'(1));
   end

   // Just after 'e' anything but a sign is judged as an exponent digit
   always_comb begin
      if (ctx.state == ST_EXP_START && !is_sign) begin
         eff_state = ST_EXP;
      end else begin
         eff_state = ctx.state;
      end
   end

   // Accept decision and next state
   always_comb begin
      take           = 1'b0;
      next_state     = eff_state;
      next_last_zero = ctx.last_zero;
      if (live) begin
         case (eff_state)
            ST_EXP_START: begin
               take       = 1'b1;
               next_state = ST_EXP;
            end
            ST_INT, ST_FRAC, ST_EXP: begin
               if (is_digit) begin
                  take           = 1'b1;
                  next_last_zero = (ch == ChZero);
               end else if (eff_state == ST_INT && ch == ChDot && flt) begin
                  take       = 1'b1;
                  next_state = ST_FRAC;
               end else if ((eff_state == ST_INT || eff_state == ST_FRAC) &&
                            (ch inside {ChLowerE, ChUpperE}) && flt) begin
                  take       = 1'b1;
                  next_state = ST_EXP_START;
               end else if (prefix_ok && hex_prefix) begin
                  take       = 1'b1;
                  next_state = ST_HEX;
               end else if (prefix_ok && bin_prefix) begin
                  take       = 1'b1;
                  next_state = ST_BIN;
               end else if (format_flags[FlagSign] && ctx.count == '0 && is_sign) begin
                  take = 1'b1;
               end
            end
            ST_HEX: take = is_digit || is_hex_letter;
            ST_BIN: take = (ch == ChZero) || (ch == ChOne);
            default: take = 1'b0;
         endcase
      end
   end

   // Kind of the token being closed
   always_comb begin
      case (ctx.state)
         ST_FRAC:              kind = KindFraction;
         ST_EXP_START, ST_EXP: kind = KindExponent;
         ST_HEX:               kind = KindHex;
         ST_BIN:               kind = KindBinary;
         default:              kind = KindInteger;
      endcase
   end

   assign below_cap = CmpBits'(ctx.count) < CmpBits'(token_capacity);

   // Result beat and next context
   always_comb begin
      result = '0;
      if (take) begin
         result.accepted = 1'b1;
         result.stored   = below_cap;
         result.char_out = ch;
         result.position = clip_out(ctx.count);
         ctx_next.state     = next_state;
         ctx_next.count     = (ctx.count != CountMax) ? ctx.count + 1'b1 : ctx.count;
         ctx_next.last_zero = next_last_zero;
      end else begin
         result.token_done   = 1'b1;
         result.token_length = clip_out(ctx.count);
         result.token_kind   = kind;
         result.truncated    = !below_cap;
         ctx_next.state      = ST_INT;
         ctx_next.count      = '0;
         ctx_next.last_zero  = 1'b0;
      end
   end

endmodule

`default_nettype wire

[hdl/nls_out_reg.sv]
// Result register: holds one result beat until the sink takes it and frees
// the slot in the same cycle. Depends on nls_pkg and nls_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module nls_out_reg (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire nls_pkg::nls_result_type  beat_in,
   output logic                          space,
   nls_rsp_if.source                     rsp_chan
);
   import nls_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   nls_result_type beat_ff;

   // Slot is free when empty or being drained this cycle
   assign space    = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.accepted     = beat_ff.accepted;
   assign rsp_chan.stored       = beat_ff.stored;
   assign rsp_chan.char_out     = beat_ff.char_out;
   assign rsp_chan.position     = beat_ff.position;
   assign rsp_chan.token_done   = beat_ff.token_done;
   assign rsp_chan.token_length = beat_ff.token_length;
   assign rsp_chan.token_kind   = beat_ff.token_kind;
   assign rsp_chan.truncated    = beat_ff.truncated;

endmodule

`default_nettype wire

[hdl/numeric_literal_scanner_core.sv]
// Top level of the numeric literal scanner: CSRs, scanner context registers,
// step logic and result register. Depends on nls_pkg, nls_channels, nls_step, nls_out_reg.
//
//   channel   | dir | handshake      | payload
//   ----------+-----+----------------+-------------------------------------------
//   req_chan  | in  | valid / ready  | ch, end_of_input
//   rsp_chan  | out | valid / ready  | accepted, stored, char_out, position,
//             |     |                | token_done, token_length, token_kind, truncated
//   csr_*     | in  | csr_we         | csr_index, csr_wdata (no read-back)
//
// One character per cycle while not stalled; each beat yields exactly one result
// beat from the result register in the next cycle. The scanner context updates at the
// accepting edge, so back-to-back characters see each other's effect.
// req_chan.ready drops only while the result register is full and the sink stalls.
// Reset is synchronous: scanner idle in the integer part, CSRs at defaults.
`timescale 1ns / 1ps
`default_nettype none

module numeric_literal_scanner_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   nls_req_if.sink                            req_chan,
   nls_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [nls_pkg::CsrIdxBits-1:0]  csr_index,
   input  wire logic [nls_pkg::CsrDataBits-1:0] csr_wdata
);
   import nls_pkg::*;

   logic [FlagsBits-1:0] format_flags_ff;
   logic [CapBits-1:0]   token_capacity_ff;
   scan_ctx_type         ctx_ff;
   scan_ctx_type         ctx_in;
   nls_result_type       result;
   logic                 space;
   logic                 accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         format_flags_ff   <= FlagsReset;
         token_capacity_ff <= CapacityReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrFormatFlags:   format_flags_ff   <= csr_wdata[FlagsBits-1:0];
            CsrTokenCapacity: token_capacity_ff <= csr_wdata[CapBits-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   // Per-character decision
   nls_step u_step (
      .ch             (req_chan.ch),
      .end_of_input   (req_chan.end_of_input),
      .format_flags   (format_flags_ff),
      .token_capacity (token_capacity_ff),
      .ctx            (ctx_ff),
      .ctx_next       (ctx_in),
      .result         (result)
   );

   // Scanner context
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.state     <= ST_INT;
         ctx_ff.count     <= '0;
         ctx_ff.last_zero <= 1'b0;
      end else if (accept) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result register
   nls_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .beat_in  (result),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

   // Every result beat either extends the token or closes it, never both
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.accepted != rsp_chan.token_done))
      else $error("result beat must be exactly one of accepted or token_done");

   // Closing a token restarts the count
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !result.accepted) |=> (ctx_ff.count == '0 && ctx_ff.state == ST_INT))
      else $error("scanner context not cleared after token close");

   // Taking a character advances the count until it saturates
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && result.accepted && ctx_ff.count != CountMax)
      |=> (ctx_ff.count == $past(ctx_ff.count) + 1'b1))
      else $error("accepted character did not advance the count");

   // Stored implies accepted on the output
   a_stored_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.stored) |-> rsp_chan.accepted)
      else $error("stored set on a beat that was not accepted");

endmodule

`default_nettype wire

[bench/nls_checker.sv]
// Scoreboard for the numeric literal scanner: follows CSR writes, predicts one
// result beat per accepted character beat and compares it with the result channel.
// Depends on nls_pkg and the channel interfaces in nls_channels.
`timescale 1ns / 1ps

module nls_checker
   import nls_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   nls_req_if                          req,
   nls_rsp_if                          rsp,
   input  wire logic                   csr_we,
   input  wire logic [CsrIdxBits-1:0]  csr_index,
   input  wire logic [CsrDataBits-1:0] csr_wdata,
   output int unsigned                 error_count,
   output int unsigned                 pending_count
);

   // Lexer state codes; the two unused codes are never entered by the lexer
   typedef enum logic [2:0] {
      LEX_INT       = 3'd0,
      LEX_UNUSED_A  = 3'd1,
      LEX_FRAC      = 3'd2,
      LEX_UNUSED_B  = 3'd3,
      LEX_EXP_START = 3'd4,
      LEX_EXP       = 3'd5,
      LEX_HEX       = 3'd6,
      LEX_BIN       = 3'd7
   } lex_state_type;

   localparam int OutLimit = (1 << OutBits) - 1;

   // Shadow CSRs and lexer context
   logic [FlagsBits-1:0]  fmt_flags;
   logic [CapBits-1:0]    capacity;
   lex_state_type         lex_state;
   logic [LengthBits-1:0] run_len;
   logic                  last_zero;

   // Predicted result beats, oldest first
   nls_result_type expected_beats[$];

   task automatic report(input string field, input int unsigned got,
                         input int unsigned want_val);
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want_val);
      error_count++;
   endtask

   // Length as seen on the output, saturated to the output width
   function automatic logic [OutBits-1:0] sat_len(input logic [LengthBits-1:0] n);
      if (int'(n) > OutLimit) return OutBits'(OutLimit);
      return OutBits'(n);
   endfunction

   function automatic logic [2:0] kind_for(input lex_state_type s);
      case (s)
         LEX_FRAC:               return KindFraction;
         LEX_EXP_START, LEX_EXP: return KindExponent;
         LEX_HEX:                return KindHex;
         LEX_BIN:                return KindBinary;
         default:                return KindInteger;
      endcase
   endfunction

   // Judge one character against the current context and advance it
   task automatic lex_step(input logic [7:0] c, input logic eoi,
                           output nls_result_type r);
      lex_state_type s;
      lex_state_type nxt;
      logic take, digit, sign, pre, hx, bn, flt;
      s     = lex_state;
      nxt   = lex_state;
      take  = 1'b0;
      digit = (c >= ChZero) && (c <= ChNine);
      sign  = (c == ChPlus) || (c == ChMinus);
      r     = '0;
      if (!eoi && (c != ChNul)) begin
         // right after e, anything but a sign is judged as an exponent digit
         if ((s == LEX_EXP_START) && !sign) s = LEX_EXP;
         if (s == LEX_EXP_START) begin
            take = 1'b1;
            nxt  = LEX_EXP;
         end else if ((s == LEX_INT) || (s == LEX_FRAC) || (s == LEX_EXP)) begin
            flt = fmt_flags[FlagFloat];
            pre = (s == LEX_INT) && last_zero && (run_len == 1);
            hx  = (fmt_flags[Flag0h] && ((c == ChLowerH) || (c == ChUpperH))) ||
                  (fmt_flags[Flag0x] && ((c == ChLowerX) || (c == ChUpperX)));
            bn  = fmt_flags[Flag0b] && ((c == ChLowerB) || (c == ChUpperB));
            if (digit) begin
               take      = 1'b1;
               nxt       = s;
               last_zero = (c == ChZero);
            end else if ((s == LEX_INT) && (c == ChDot) && flt) begin
               take = 1'b1;
               nxt  = LEX_FRAC;
            end else if (((s == LEX_INT) || (s == LEX_FRAC)) &&
                         ((c == ChLowerE) || (c == ChUpperE)) && flt) begin
               take = 1'b1;
               nxt  = LEX_EXP_START;
            end else if (pre && hx) begin
               take = 1'b1;
               nxt  = LEX_HEX;
            end else if (pre && bn) begin
               take = 1'b1;
               nxt  = LEX_BIN;
            end else if (fmt_flags[FlagSign] && (run_len == 0) && sign) begin
               take = 1'b1;
               nxt  = s;
            end
         end else if (s == LEX_HEX) begin
            take = digit || ((c >= ChLowerA) && (c <= ChLowerF)) ||
                   ((c >= ChUpperA) && (c <= ChUpperF));
         end else if (s == LEX_BIN) begin
            take = (c == ChZero) || (c == ChOne);
         end
      end

      if (take) begin
         r.accepted = 1'b1;
         r.stored   = run_len < capacity;
         r.char_out = c;
         r.position = sat_len(run_len);
         if (run_len != CountMax) run_len++;
         lex_state = nxt;
      end else begin
         // token closes; the character is not part of it and is not judged again
         r.token_done   = 1'b1;
         r.token_length = sat_len(run_len);
         r.token_kind   = kind_for(lex_state);
         r.truncated    = run_len >= capacity;
         lex_state      = LEX_INT;
         run_len        = '0;
         last_zero      = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      nls_result_type want;
      if (reset) begin
         fmt_flags = FlagsReset;
         capacity  = CapacityReset;
         lex_state = LEX_INT;
         run_len   = '0;
         last_zero = 1'b0;
         expected_beats.delete();
      end else begin
         // CSR writes
         if (csr_we) begin
            case (csr_index)
               CsrFormatFlags:   fmt_flags = csr_wdata[FlagsBits-1:0];
               CsrTokenCapacity: capacity  = csr_wdata[CapBits-1:0];
               default: ;
            endcase
         end
         // result beat against the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (expected_beats.size() == 0) begin
               report("unexpected result beat", 1, 0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp.accepted !== want.accepted)
                  report("accepted", rsp.accepted, want.accepted);
               if (rsp.stored !== want.stored)
                  report("stored", rsp.stored, want.stored);
               if (rsp.char_out !== want.char_out)
                  report("char_out", rsp.char_out, want.char_out);
               if (rsp.position !== want.position)
                  report("position", rsp.position, want.position);
               if (rsp.token_done !== want.token_done)
                  report("token_done", rsp.token_done, want.token_done);
               if (rsp.token_length !== want.token_length)
                  report("token_length", rsp.token_length, want.token_length);
               if (rsp.token_kind !== want.token_kind)
                  report("token_kind", rsp.token_kind, want.token_kind);
               if (rsp.truncated !== want.truncated)
                  report("truncated", rsp.truncated, want.truncated);
            end
         end
         // character beat: predict its result
         if (req.valid && req.ready) begin
            lex_step(req.ch, req.end_of_input, want);
            expected_beats.push_back(want);
         end
      end
      pending_count = expected_beats.size();
   end

endmodule

[bench/testbench.sv]
// Top of the scanner bench: clock, reset, character stimulus, result-side pacing,
// CSR phases and the verdict. Depends on nls_pkg, nls_channels, nls_checker
// and numeric_literal_scanner_core.
`timescale 1ns / 1ps

module testbench;
   import nls_pkg::*;

   localparam int CycleLimit = 1_000_000;

   typedef enum int {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_MASK} pace_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CsrIdxBits-1:0]  csr_index = '0;
   logic [CsrDataBits-1:0] csr_wdata = '0;
   logic                   rsp_hold  = 1'b0;
   int unsigned            error_count;
   int unsigned            pending_count;
   int unsigned            cycle_count = 0;
   int                     burst_left  = 0;
   logic [8:0]             char_plan[$];   // {end_of_input, ch}

   nls_req_if req_chan ();
   nls_rsp_if rsp_chan ();

   numeric_literal_scanner_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nls_checker scan_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // One long result-side hold-off so the result register fills and input stalls
   initial begin : long_hold
      repeat (250) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Result-side ready, changing to a new random pattern after each random span
   initial begin : sink_pacing
      pace_type   mode;
      int         span;
      logic [7:0] mask;
      forever begin
         mode = pace_type'($urandom_range(0, 3));
         span = $urandom_range(16, 96);
         mask = $urandom;
         repeat (span) begin
            @(negedge clock);
            if (rsp_hold) begin
               rsp_chan.ready <= 1'b0;
            end else begin
               case (mode)
                  PACE_OPEN:   rsp_chan.ready <= 1'b1;
                  PACE_COIN:   rsp_chan.ready <= $urandom_range(0, 1);
                  PACE_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
                  default: begin
                     rsp_chan.ready <= mask[0];
                     mask = {mask[0], mask[7:1]};
                  end
               endcase
            end
         end
      end
   end

   // Offer one character beat, in bursts with random gaps; returns at the
   // falling edge after it was taken
   task automatic send_beat(input logic [7:0] c, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.ch           <= c;
      req_chan.end_of_input <= eoi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // Stop offering and wait until every predicted result has come out
   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write both CSRs on consecutive cycles; upper data bits are don't-care for flags
   task automatic configure(input logic [FlagsBits-1:0] flags, input logic [CapBits-1:0] cap);
      csr_we    <= 1'b1;
      csr_index <= CsrFormatFlags;
      csr_wdata <= {7'($urandom), flags};
      @(negedge clock);
      csr_index <= CsrTokenCapacity;
      csr_wdata <= cap;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [7:0] either(input logic [7:0] a, input logic [7:0] b);
      return $urandom_range(0, 1) ? a : b;
   endfunction

   function automatic logic [7:0] rand_digit();
      return ChZero + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_hex();
      int r;
      r = $urandom_range(0, 15);
      if (r < 10) return ChZero + 8'(r);
      return either(ChLowerA + 8'(r - 10), ChUpperA + 8'(r - 10));
   endfunction

   task automatic push_char(input logic [7:0] c);
      char_plan.push_back({1'b0, c});
   endtask

   // Plan one literal, mostly well formed, sometimes broken, then in most plans a terminator
   task automatic plan_token();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll <= 1) begin
         // signed integer
         if ($urandom_range(0, 2) == 0) push_char(either(ChPlus, ChMinus));
         repeat ($urandom_range(1, 5)) push_char(rand_digit());
      end else if (roll <= 4) begin
         // fraction and exponent
         if ($urandom_range(0, 3) == 0) push_char(either(ChPlus, ChMinus));
         repeat ($urandom_range(0, 4)) push_char(rand_digit());
         if ($urandom_range(0, 3) != 0) begin
            push_char(ChDot);
            repeat ($urandom_range(0, 4)) push_char(rand_digit());
         end
         if ($urandom_range(0, 1) != 0) begin
            push_char(either(ChLowerE, ChUpperE));
            if ($urandom_range(0, 1) != 0) push_char(either(ChPlus, ChMinus));
            repeat ($urandom_range(0, 3)) push_char(rand_digit());
         end
      end else if (roll <= 6) begin
         // hex with either prefix letter
         push_char(ChZero);
         push_char($urandom_range(0, 1) ? either(ChLowerX, ChUpperX)
                                        : either(ChLowerH, ChUpperH));
         repeat ($urandom_range(1, 6)) push_char(rand_hex());
      end else if (roll <= 8) begin
         push_char(ChZero);
         push_char(either(ChLowerB, ChUpperB));
         repeat ($urandom_range(1, 8)) push_char(either(ChZero, ChOne));
      end else begin
         repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)));
      end
      // broken literal: one character replaced by a random byte
      if (char_plan.size() != 0 && $urandom_range(0, 4) == 0)
         char_plan[$urandom_range(0, char_plan.size() - 1)] = {1'b0, 8'($urandom)};
      case ($urandom_range(0, 5))
         0: push_char(ChNul);
         1: char_plan.push_back({1'b1, 8'($urandom)});
         2: push_char(8'h20);
         3: push_char(8'($urandom_range(0, 255)));
         default: ;
      endcase
   endtask

   task automatic flush_plan(inout int sent);
      logic [8:0] beat;
      while (char_plan.size() != 0) begin
         beat = char_plan.pop_front();
         send_beat(beat[7:0], beat[8]);
         sent++;
      end
   endtask

   // One CSR setting followed by random literals
   task automatic run_phase(input logic [FlagsBits-1:0] flags, input logic [CapBits-1:0] cap,
                            input int count, input logic long_token);
      int sent;
      sent = 0;
      drain();
      configure(flags, cap);
      if (long_token) begin
         // long enough to run well past the capacity
         repeat (150) push_char(rand_digit());
         char_plan.push_back({1'b1, 8'($urandom)});
         flush_plan(sent);
      end
      while (sent < count) begin
         plan_token();
         flush_plan(sent);
      end
   endtask

   initial begin : stimulus
      req_chan.valid        = 1'b0;
      req_chan.ch           = '0;
      req_chan.end_of_input = 1'b0;
      rsp_chan.ready        = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed literals at reset settings
      send_text("+12.5e-9");
      send_beat(8'hFF, 1'b0);
      send_text("0xFa");
      send_beat(ChNul, 1'b0);
      send_text("0B10");
      send_beat(8'hA5, 1'b1);
      send_text("1E3.");       // dot closes an exponent
      send_text("00x");        // prefix letter after two digits is rejected

      // CSR phases, extremes included
      run_phase(5'd31, 12'd64, 300, 1'b0);
      run_phase(5'd0, 12'd0, 200, 1'b0);
      run_phase(5'($urandom_range(0, 31)), 12'd1, 250, 1'b0);
      run_phase(5'd31, 12'd100, 150, 1'b1);
      run_phase(5'($urandom_range(0, 31)), 12'($urandom_range(1, 8)), 300, 1'b0);
      run_phase(5'($urandom_range(0, 31)), 12'($urandom_range(1, 4095)), 300, 1'b0);
      run_phase(5'd31, 12'd5, 300, 1'b0);

      drain();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/nls_pkg.sv
hdl/nls_channels.sv
hdl/nls_step.sv
hdl/nls_out_reg.sv
hdl/numeric_literal_scanner_core.sv
bench/nls_checker.sv
bench/testbench.sv
